// ----- sv/bounded_compacting_list_defines.svh -----
// Assertion macros shared by the project.
`ifndef BOUNDED_COMPACTING_LIST_DEFINES_SVH
`define BOUNDED_COMPACTING_LIST_DEFINES_SVH

// Same-cycle implication.
`define BCL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcl: implication failed");

// Next-cycle implication.
`define BCL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcl: next-cycle implication failed");

`endif

// ----- sv/bcl_pkg.sv -----
`timescale 1ns / 1ps

package bcl_pkg;

	localparam int COUNT_W  = 5;
	localparam int INDEX_W  = 4;
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RDATA,
		S_SHIFT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [INDEX_W-1:0] index;
		logic [DATA_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]   read_value;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
	} out_item_t;

endpackage

// ----- sv/bounded_compacting_list.sv -----
// Bounded compacting list: up to DEPTH words kept packed from position zero in one
// simple dual-port synchronous RAM (one write and one read per cycle, registered read
// data). Commands are append, remove-at-index and read-at-index; every command
// transfer yields one result with the read word, the count after the command and a
// status. One command is in work at a time; the next transfer is taken once the result
// has entered the output register, which holds it until the consumer takes it. Append,
// unused codes, rejected commands and a remove of the last entry go straight to the
// finish state; a read passes the read-data state; any other remove moves one word down
// per cycle in the shift state via the single RAM write port. The capacity clamps to 1..DEPTH.
`timescale 1ns / 1ps
`include "bounded_compacting_list_defines.svh"

module bounded_compacting_list #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bcl_pkg::COUNT_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bcl_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bcl_pkg::out_item_t          out_data
);

	import bcl_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [WORD_WIDTH-1:0] ram_rdata;

	bcl_ram #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bcl_ctrl #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	`BCL_ASSERT_IMP(a_no_rw_collide, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`BCL_ASSERT_NXT(a_busy_after_transfer, clk, arst_n, in_valid && !in_stall, in_stall)
	`BCL_ASSERT_IMP(a_zero_on_error, clk, arst_n, out_valid && out_data.status != ST_OK, out_data.read_value == '0)
	`BCL_ASSERT_IMP(a_full_nonempty, clk, arst_n, out_valid && out_data.status == ST_FULL, out_data.count != '0)

endmodule

// ----- sv/bcl_ram.sv -----
`timescale 1ns / 1ps

module bcl_ram #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WORD_WIDTH-1:0]    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WORD_WIDTH-1:0]    rdata
);

	logic [WORD_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/bcl_ctrl.sv -----
`timescale 1ns / 1ps

module bcl_ctrl #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcl_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bcl_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bcl_pkg::out_item_t            out_data,
	output logic                          ram_we,
	output logic [$clog2(DEPTH)-1:0]      ram_waddr,
	output logic [WORD_WIDTH-1:0]         ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(DEPTH)-1:0]      ram_raddr,
	input  logic [WORD_WIDTH-1:0]         ram_rdata
);

	import bcl_pkg::*;

	localparam int AW       = $clog2(DEPTH);
	localparam int COUNT_MX = (1 << COUNT_W) - 1;
	localparam logic [COUNT_W-1:0] CAP_MAX =
		COUNT_W'((DEPTH < COUNT_MX) ? DEPTH : COUNT_MX);

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W-1:0] ptr_q, ptr_d;
	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] eff_cap;
	logic [COUNT_W-1:0] idx_ext;
	logic               full;
	logic               out_valid_q;
	logic               out_load;
	out_item_t          pend_q, pend_d;
	out_item_t          out_q;

	assign idx_ext   = COUNT_W'(in_data.index);
	assign eff_cap   = (cap_q == '0) ? COUNT_W'(1) : ((cap_q > CAP_MAX) ? CAP_MAX : cap_q);
	assign full      = (count_q >= eff_cap);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		pend_d    = pend_q;
		ram_we    = 1'b0;
		ram_waddr = AW'(count_q);
		ram_wdata = WORD_WIDTH'(in_data.value);
		ram_re    = 1'b0;
		ram_raddr = AW'(in_data.index);
		in_stall  = (state_q != S_IDLE);
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					pend_d.read_value = '0;
					pend_d.count      = count_q;
					pend_d.status     = ST_OK;
					state_d           = S_FINISH;
					case (in_data.command)
						CMD_APPEND: begin
							if (full) begin
								pend_d.status = ST_FULL;
							end else begin
								ram_we       = 1'b1;
								count_d      = count_q + COUNT_W'(1);
								pend_d.count = count_q + COUNT_W'(1);
							end
						end
						CMD_REMOVE: begin
							if (idx_ext >= count_q) begin
								pend_d.status = ST_BAD_INDEX;
							end else if (idx_ext + COUNT_W'(1) == count_q) begin
								count_d      = count_q - COUNT_W'(1);
								pend_d.count = count_q - COUNT_W'(1);
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(idx_ext + COUNT_W'(1));
								ptr_d     = idx_ext;
								state_d   = S_SHIFT;
							end
						end
						CMD_READ: begin
							if (idx_ext >= count_q) begin
								pend_d.status = ST_BAD_INDEX;
							end else begin
								ram_re  = 1'b1;
								state_d = S_RDATA;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RDATA: begin
				pend_d.read_value = DATA_W'(ram_rdata);
				state_d           = S_FINISH;
			end
			S_SHIFT: begin
				// move entry ptr+1 down to ptr, fetch the next one while one remains
				ram_we    = 1'b1;
				ram_waddr = AW'(ptr_q);
				ram_wdata = ram_rdata;
				if ({1'b0, ptr_q} + (COUNT_W + 1)'(2) < {1'b0, count_q}) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(ptr_q + COUNT_W'(2));
					ptr_d     = ptr_q + COUNT_W'(1);
				end else begin
					count_d      = count_q - COUNT_W'(1);
					pend_d.count = count_q - COUNT_W'(1);
					state_d      = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
